// ===== design/plsd_pkg.sv =====
// ----------------------------------------------------------------------------
// plsd_pkg
// Shared types and constants of the posting-list stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package plsd_pkg;

    localparam int DOC_W       = 64;
    localparam int POS_W       = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 104;
    localparam int QUEUE_DEPTH = 2;
    localparam int ID_BYTES    = 8;
    localparam int VARINT_MAX  = 5;

    typedef enum logic [1:0] {
        KIND_POS   = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_ID    = 2'd0,
        PH_COUNT = 2'd1,
        PH_POS   = 2'd2,
        PH_DRAIN = 2'd3
    } t_phase;

    // one accepted byte's worth of results: an optional decoded result,
    // optionally followed by a truncation error
    typedef struct packed {
        logic [DOC_W-1:0] doc_id;
        logic [POS_W-1:0] position;
        t_kind            first_kind;
        logic             doc_done;
        logic             first_v;
        logic             err2;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/plsd_front.sv =====
// ----------------------------------------------------------------------------
// plsd_front
// Accepts buffer bytes, parses doc ids and varints, queues result commands.
// ----------------------------------------------------------------------------
`default_nettype none

module plsd_front
    import plsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_full,
    output logic            o_ready,
    output logic            o_push,
    output t_cmd            o_cmd
);

    t_phase            r_phase, n_phase;
    logic [2:0]        r_id_cnt, n_id_cnt;
    logic [DOC_W-1:0]  r_doc, n_doc;
    logic [POS_W-1:0]  r_vacc, n_vacc;
    logic [2:0]        r_vb, n_vb;
    logic [POS_W-1:0]  r_left, n_left;

    logic              acc;
    logic [POS_W-1:0]  ins;
    logic [POS_W-1:0]  v_val;
    logic [2:0]        vb_inc;
    logic              v_done;
    logic              v_over;
    logic [POS_W-1:0]  left_dec;

    assign o_ready  = ~i_full;
    assign acc      = i_valid & o_ready;
    assign left_dec = r_left - POS_W'(1);

    always_comb begin
        unique case (r_vb)
            3'd0:    ins = {25'b0, i_byte[6:0]};
            3'd1:    ins = {18'b0, i_byte[6:0], 7'b0};
            3'd2:    ins = {11'b0, i_byte[6:0], 14'b0};
            3'd3:    ins = {4'b0, i_byte[6:0], 21'b0};
            3'd4:    ins = {i_byte[3:0], 28'b0};
            default: ins = '0;
        endcase
        v_val  = r_vacc | ins;
        vb_inc = r_vb + 3'd1;
        v_done = ~i_byte[7];
        v_over = i_byte[7] & (vb_inc >= 3'(VARINT_MAX));
    end

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_id_cnt = r_id_cnt;
        n_doc    = r_doc;
        n_vacc   = r_vacc;
        n_vb     = r_vb;
        n_left   = r_left;
        if (acc) begin
            unique case (r_phase)
                PH_ID: begin
                    if (r_id_cnt == 3'd0) begin
                        n_doc = {{(DOC_W-8){1'b0}}, i_byte};
                    end else begin
                        n_doc[{r_id_cnt, 3'b000} +: 8] = i_byte;
                    end
                    if (r_id_cnt == 3'(ID_BYTES-1)) begin
                        n_id_cnt = 3'd0;
                        n_phase  = PH_COUNT;
                    end else begin
                        n_id_cnt = r_id_cnt + 3'd1;
                    end
                end
                PH_COUNT, PH_POS: begin
                    if (v_done || v_over) begin
                        n_vacc = '0;
                        n_vb   = 3'd0;
                    end else begin
                        n_vacc = v_val;
                        n_vb   = vb_inc;
                    end
                    if (v_over) begin
                        n_phase = PH_DRAIN;
                    end else if (v_done && r_phase == PH_COUNT) begin
                        n_left  = v_val;
                        n_phase = (v_val == '0) ? PH_ID : PH_POS;
                    end else if (v_done) begin
                        n_left = left_dec;
                        if (left_dec == '0) begin
                            n_phase = PH_ID;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (i_last) begin
                n_phase  = PH_ID;
                n_id_cnt = 3'd0;
                n_vacc   = '0;
                n_vb     = 3'd0;
                n_left   = '0;
            end
        end
    end

    // outputs
    always_comb begin
        logic errored;
        logic midrec;
        o_cmd            = '0;
        o_cmd.first_kind = KIND_ERR;
        errored          = 1'b0;
        unique case (r_phase)
            PH_COUNT: begin
                if (v_over) begin
                    o_cmd.first_v = 1'b1;
                    errored       = 1'b1;
                end else if (v_done && v_val == '0) begin
                    o_cmd.first_v    = 1'b1;
                    o_cmd.first_kind = KIND_EMPTY;
                    o_cmd.doc_done   = 1'b1;
                end
            end
            PH_POS: begin
                if (v_over) begin
                    o_cmd.first_v = 1'b1;
                    errored       = 1'b1;
                end else if (v_done) begin
                    o_cmd.first_v    = 1'b1;
                    o_cmd.first_kind = KIND_POS;
                    o_cmd.position   = v_val;
                    o_cmd.doc_done   = (left_dec == '0);
                end
            end
            PH_DRAIN: errored = 1'b1;
            default: begin
            end
        endcase
        midrec = (r_phase == PH_COUNT && !(v_done && v_val == '0))
               || (r_phase == PH_POS && !(v_done && left_dec == '0))
               || (r_phase == PH_ID && r_id_cnt != 3'(ID_BYTES-1))
               || (r_phase == PH_ID && r_id_cnt == 3'(ID_BYTES-1));
        o_cmd.err2   = i_last & midrec & ~errored;
        o_cmd.doc_id = n_doc;
        o_push       = acc & (o_cmd.first_v | o_cmd.err2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ID;
            r_id_cnt <= 3'd0;
            r_doc    <= '0;
            r_vacc   <= '0;
            r_vb     <= 3'd0;
            r_left   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_id_cnt <= n_id_cnt;
            r_doc    <= n_doc;
            r_vacc   <= n_vacc;
            r_vb     <= n_vb;
            r_left   <= n_left;
        end
    end

endmodule

`default_nettype wire

// ===== design/plsd_queue.sv =====
// ----------------------------------------------------------------------------
// plsd_queue
// Small register queue of result commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module plsd_queue
    import plsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== design/plsd_back.sv =====
// ----------------------------------------------------------------------------
// plsd_back
// Expands queued commands into result items behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plsd_back
    import plsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    input  wire logic        i_ready,
    output logic             o_valid,
    output t_kind            o_kind,
    output logic [DOC_W-1:0] o_doc_id,
    output logic [POS_W-1:0] o_position,
    output logic             o_doc_done,
    output logic             o_run_last
);

    logic             r_valid, n_valid;
    logic             r_sec, n_sec;
    t_kind            r_kind, n_kind;
    logic [DOC_W-1:0] r_doc, n_doc;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_done, n_done;
    logic             r_last, n_last;
    logic             load;

    assign load = ~r_valid | i_ready;

    always_comb begin
        n_valid = r_valid;
        n_sec   = r_sec;
        n_kind  = r_kind;
        n_doc   = r_doc;
        n_pos   = r_pos;
        n_done  = r_done;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (load && i_valid) begin
            n_valid = 1'b1;
            n_doc   = i_cmd.doc_id;
            if (r_sec || !i_cmd.first_v) begin
                n_kind = KIND_ERR;
                n_pos  = '0;
                n_done = 1'b0;
                n_last = 1'b1;
                n_sec  = 1'b0;
                o_pop  = 1'b1;
            end else begin
                n_kind = i_cmd.first_kind;
                n_pos  = i_cmd.position;
                n_done = i_cmd.doc_done;
                n_last = ~i_cmd.err2;
                n_sec  = i_cmd.err2;
                o_pop  = ~i_cmd.err2;
            end
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_doc  <= n_doc;
        r_pos  <= n_pos;
        r_done <= n_done;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sec   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sec   <= n_sec;
        end
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_doc_id   = r_doc;
    assign o_position = r_pos;
    assign o_doc_done = r_done;
    assign o_run_last = r_last;

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == KIND_ERR |-> r_pos == '0 && !r_done && r_last)
        else $error("malformed error result");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_done |-> r_last) else $error("record end not run end");
    a_sec_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec |-> r_valid && !r_last) else $error("pending error without lead");

endmodule

`default_nettype wire

// ===== design/position_list_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// position_list_stream_decoder
// Posting-list byte stream to (doc id, position) result stream.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                  | tuser | tlast
// s_axis  | in  | data_byte                              | -     | buffer_end
// m_axis  | out | doc_id, position, doc_done (104 bits)  | kind  | run_last
//
// One byte per cycle while the queue is not full; each byte is parsed in the
// cycle it is taken. A byte with two results (position plus truncation error)
// fills the output register with each in turn; the command queue absorbs the
// difference. Results go from the front parse into the queue, queue to output.
// Reset (synchronous, i_rst_n low) returns the parser to idle, empties the
// queue and drops any result not yet taken. m_axis stalls back up through
// the queue into s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module position_list_stream_decoder
    import plsd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic                   s_axis_tlast,   // buffer_end
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // doc_id, position, doc_done
    output logic [1:0]                  m_axis_tuser,   // kind
    output logic                        m_axis_tlast    // run_last
);

    logic             push, pop, full, q_valid;
    t_cmd             f_cmd, q_cmd;
    t_kind            kind;
    logic [DOC_W-1:0] doc_id;
    logic [POS_W-1:0] position;
    logic             doc_done;

    plsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_cmd   (f_cmd)
    );

    plsd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    plsd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_kind     (kind),
        .o_doc_id   (doc_id),
        .o_position (position),
        .o_doc_done (doc_done),
        .o_run_last (m_axis_tlast)
    );

    assign m_axis_tuser = kind;
    assign m_axis_tdata = {7'b0, doc_done, position, doc_id};

endmodule

`default_nettype wire
